// ===== hdl/integer_to_ascii_formatter_macros.svh =====
// Assertion helpers for the integer to ASCII formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
`define ITAF_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error("%m failed");
`define ITAF_ASSERT_NR(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) else $error("%m failed");
`else
`define ITAF_ASSERT(label, clk_s, rst_s, prop)
`define ITAF_ASSERT_NR(label, clk_s, prop)
`endif
`endif

// ===== hdl/itaf_pkg.sv =====
`default_nettype none
package itaf_pkg;
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] WC_8    = 2'd0;
  localparam logic [1:0] WC_16   = 2'd1;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LETTER = 8'h41;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam int NDIG = 10;

  // one decoded number: BCD digits or hex nibbles, least significant at index 0
  typedef struct packed {
    logic        hex;
    logic        neg;
    logic [39:0] digits;
    logic [3:0]  ndig;
  } num_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_LETTER + {4'd0, d} - 8'd10);
  endfunction
endpackage
`default_nettype wire

// ===== hdl/itaf_bcd.sv =====
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"
// Pipelined double-dabble: 32 shift steps, 4 per stage, 8 stages.
module itaf_bcd (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        stall,
  input  wire logic        in_valid,
  input  wire logic        in_hex,
  input  wire logic        in_neg,
  input  wire logic [3:0]  in_ndig,
  input  wire logic [31:0] in_mag,
  output logic             out_valid,
  output itaf_pkg::num_t   out_num
);
  localparam int NST = 8;
  localparam int SPS = 4;

  logic [NST-1:0] vld;
  logic [71:0]    work [NST];
  logic           hexr [NST];
  logic           negr [NST];
  logic [3:0]     ndr  [NST];

  function automatic logic [71:0] dabble(input logic [71:0] w, input logic hex);
    logic [71:0] t;
    t = w;
    for (int s = 0; s < SPS; s++) begin
      if (!hex) begin
        for (int d = 0; d < 10; d++) begin
          if (t[32+4*d +: 4] >= 4'd5) t[32+4*d +: 4] = t[32+4*d +: 4] + 4'd3;
        end
      end
      t = {t[70:0], 1'b0};
    end
    dabble = t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (!stall) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      work[0] <= dabble({40'd0, in_mag}, in_hex);
      hexr[0] <= in_hex;
      negr[0] <= in_neg;
      ndr[0]  <= in_ndig;
      for (int k = 1; k < NST; k++) begin
        work[k] <= dabble(work[k-1], hexr[k-1]);
        hexr[k] <= hexr[k-1];
        negr[k] <= negr[k-1];
        ndr[k]  <= ndr[k-1];
      end
    end
  end

  always_comb begin
    out_valid      = vld[NST-1];
    out_num.hex    = hexr[NST-1];
    out_num.neg    = negr[NST-1];
    out_num.digits = work[NST-1][71:32];
    out_num.ndig   = ndr[NST-1];
  end

  `ITAF_ASSERT(a_hold, clk, rst, stall |=> out_valid == $past(out_valid))
  `ITAF_ASSERT_NR(a_rst, clk, rst |=> !out_valid)
  `ITAF_ASSERT(a_ndig, clk, rst, out_valid && out_num.hex |-> out_num.ndig <= 4'd8)
endmodule
`default_nettype wire

// ===== hdl/itaf_emit.sv =====
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"
// Character sequencer: holds one number and sends its characters one a cycle while out_stall is low.
module itaf_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire itaf_pkg::num_t in_num,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          character,
  output logic                is_last,
  output logic [3:0]          char_count
);
  logic           busy;
  itaf_pkg::num_t num;
  logic [3:0]     pos;
  logic [3:0]     total;
  logic           minus_pend;
  logic [3:0]     lead;
  logic [3:0]     cnt;
  logic [3:0]     cur_d;
  logic           fin;

  // count of significant decimal digits, or the fixed digit count in hex
  always_comb begin
    lead = 4'd1;
    for (int d = 0; d < 10; d++) begin
      if (in_num.digits[4*d +: 4] != 4'd0) lead = 4'(d + 1);
    end
    cnt = in_num.hex ? in_num.ndig : lead;
  end

  assign cur_d     = num.digits[4*pos +: 4];
  assign fin       = !minus_pend && pos == 4'd0;
  assign out_valid = busy;
  assign in_stall  = busy && !(fin && !out_stall);
  assign character = minus_pend ? itaf_pkg::CH_MINUS : itaf_pkg::digit_char(cur_d);
  assign is_last   = fin;
  assign char_count = fin ? total : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!in_stall) begin
      busy <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      num        <= in_num;
      pos        <= cnt - 4'd1;
      minus_pend <= in_num.neg;
      total      <= cnt + {3'd0, in_num.neg};
    end else if (busy && !out_stall) begin
      if (minus_pend) minus_pend <= 1'b0;
      else pos <= pos - 4'd1;
    end
  end

  `ITAF_ASSERT(a_stable, clk, rst, out_valid && out_stall |=> out_valid && $stable(character))
  `ITAF_ASSERT(a_cnt, clk, rst, out_valid && is_last |-> char_count != 4'd0)
  `ITAF_ASSERT(a_mid, clk, rst, out_valid && !is_last |-> char_count == 4'd0)
endmodule
`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// A number passes the input register and the BCD pipeline; one character
// per cycle then leaves while out_stall is low, 1 to 11 per number. The
// single character sequencer at the output sets the pace and takes a new
// number with the last character; the BCD pipeline overlaps numbers.
// Reset: synchronous active-high rst empties all stages; no tables to clear.
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"
module integer_to_ascii_formatter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [1:0]  width_code,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       character,
  output logic             is_last,
  output logic [3:0]       char_count
);
  // stage 0: mask to width, form magnitude, register
  logic        s0_valid;
  logic        s0_hex;
  logic        s0_neg;
  logic [3:0]  s0_ndig;
  logic [31:0] s0_mag;
  logic        pipe_stall;
  logic        emit_stall;
  logic        bcd_valid;
  itaf_pkg::num_t bcd_num;

  logic [31:0] v_m;
  logic        sgn;
  logic        hex_c;
  logic [31:0] mag_c;
  logic [31:0] hex_al;

  always_comb begin
    hex_c = operation[1];
    case (width_code)
      itaf_pkg::WC_8:  begin v_m = {24'd0, value[7:0]};  sgn = value[7];  end
      itaf_pkg::WC_16: begin v_m = {16'd0, value[15:0]}; sgn = value[15]; end
      default:         begin v_m = value;                sgn = value[31]; end
    endcase
    sgn   = sgn && operation == itaf_pkg::OP_SDEC;
    mag_c = v_m;
    if (sgn) begin
      case (width_code)
        itaf_pkg::WC_8:  mag_c = {24'd0, 8'(~value[7:0] + 8'd1)};
        itaf_pkg::WC_16: mag_c = {16'd0, 16'(~value[15:0] + 16'd1)};
        default:         mag_c = ~value + 32'd1;
      endcase
      if (mag_c == 32'd0) mag_c = v_m;
    end
    // hex nibbles land in the 8 low digit slots after 32 shifts
    hex_al = v_m;
  end

  assign pipe_stall = bcd_valid && emit_stall;
  assign in_stall   = pipe_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!pipe_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pipe_stall) begin
      s0_hex  <= hex_c;
      s0_neg  <= sgn;
      s0_mag  <= hex_c ? hex_al : mag_c;
      case (width_code)
        itaf_pkg::WC_8:  s0_ndig <= 4'd2;
        itaf_pkg::WC_16: s0_ndig <= 4'd4;
        default:         s0_ndig <= 4'd8;
      endcase
    end
  end

  itaf_bcd u_bcd (
    .clk(clk), .rst(rst), .stall(pipe_stall),
    .in_valid(s0_valid), .in_hex(s0_hex), .in_neg(s0_neg),
    .in_ndig(s0_ndig), .in_mag(s0_mag),
    .out_valid(bcd_valid), .out_num(bcd_num)
  );

  itaf_emit u_emit (
    .clk(clk), .rst(rst),
    .in_valid(bcd_valid), .in_stall(emit_stall), .in_num(bcd_num),
    .out_valid(out_valid), .out_stall(out_stall),
    .character(character), .is_last(is_last), .char_count(char_count)
  );

  // a stalled output transaction keeps its flag and count
  `ITAF_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(is_last) && $stable(char_count))
  `ITAF_ASSERT(a_max, clk, rst, out_valid |-> char_count <= 4'd11)
  `ITAF_ASSERT(a_in_hold, clk, rst, in_stall |-> bcd_valid)
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation and width codes beyond the package constants
  localparam logic [1:0] OP_HEX   = 2'd2;
  localparam logic [1:0] OP_HEX_B = 2'd3;  // upper op bit alone selects hex
  localparam logic [1:0] WC_32    = 2'd2;
  localparam logic [1:0] WC_32_B  = 2'd3;  // width code three acts as 32 bits
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [3:0] count;
  } char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [1:0]  width_code = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  character;
  logic        is_last;
  logic [3:0]  char_count;

  char_t pending_chars[$];
  int    fail_count = 0;
  int    numbers_sent = 0;
  int    chars_seen = 0;
  int    idle_cycles = 0;
  bit    hold_output = 1'b0;  // long receiver hold-off while set
  bit    gaps_on = 1'b1;

  always #10 clk = ~clk;

  integer_to_ascii_formatter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .width_code(width_code), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .character(character), .is_last(is_last), .char_count(char_count)
  );

  // Build the character string of one number and queue it as expected output
  task automatic queue_formatted(input logic [1:0] op, input logic [1:0] wc,
                                 input logic [31:0] raw);
    int          nbits;
    logic [31:0] mask;
    logic [31:0] v;
    logic [31:0] mag;
    logic [7:0]  text[$];
    logic [7:0]  digs[$];
    logic [3:0]  nib;
    char_t       c;
    nbits = (wc == itaf_pkg::WC_8) ? 8 : (wc == itaf_pkg::WC_16) ? 16 : 32;
    mask = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
    v = raw & mask;
    if (op[1]) begin
      for (int i = nbits / 4 - 1; i >= 0; i--) begin
        nib = v[i*4 +: 4];
        text.push_back((nib < 4'd10) ? 8'(itaf_pkg::CH_ZERO + {4'd0, nib})
                                     : 8'(itaf_pkg::CH_LETTER + {4'd0, nib} - 8'd10));
      end
    end else begin
      mag = v;
      if (op == itaf_pkg::OP_SDEC && v[nbits-1]) begin
        mag = (~v + 32'd1) & mask;
        if (mag == 32'd0) mag = 32'd1 << (nbits - 1);
        text.push_back(itaf_pkg::CH_MINUS);
      end
      do begin
        digs.push_front(8'(itaf_pkg::CH_ZERO + 8'(mag % 32'd10)));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      foreach (digs[i]) text.push_back(digs[i]);
    end
    foreach (text[i]) begin
      c.ch = text[i];
      c.last = (i == text.size() - 1);
      c.count = c.last ? 4'(text.size()) : 4'd0;
      pending_chars.push_back(c);
    end
  endtask

  // Offer one number, holding it until a transaction completes; valid stays
  // high afterwards so back-to-back numbers go without a gap
  task automatic send_number(input logic [1:0] op, input logic [1:0] wc,
                             input logic [31:0] raw);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    width_code <= wc;
    value <= raw;
    do @(posedge clk); while (in_stall);
    queue_formatted(op, wc, raw);
    numbers_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Receiver stall: random short/long stretches, plus a forced hold-off
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_output) out_stall <= 1'b1;
    else if (!gaps_on) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 4) == 0);
  end

  // Compare every transaction on the output with the oldest expected char
  always @(posedge clk) begin
    char_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h", character);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.ch) begin
          $error("character: expected %h actual %h", want.ch, character);
          fail_count++;
        end
        if (is_last !== want.last) begin
          $error("is_last: expected %b actual %b", want.last, is_last);
          fail_count++;
        end
        if (char_count !== want.count) begin
          $error("char_count: expected %0d actual %0d", want.count, char_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Widths, zero, extremes, most negative values, and junk upper bits
  task automatic test_directed();
    send_number(itaf_pkg::OP_UDEC, itaf_pkg::WC_8, 32'h0);
    send_number(itaf_pkg::OP_UDEC, itaf_pkg::WC_8, 32'hFF);
    send_number(itaf_pkg::OP_UDEC, itaf_pkg::WC_16, 32'hFFFF);
    send_number(itaf_pkg::OP_UDEC, WC_32, 32'hFFFF_FFFF);
    send_number(itaf_pkg::OP_UDEC, WC_32, 32'd1_000_000_000);
    send_number(itaf_pkg::OP_UDEC, itaf_pkg::WC_16, 32'd10000);
    send_number(itaf_pkg::OP_SDEC, itaf_pkg::WC_8, 32'h80);
    send_number(itaf_pkg::OP_SDEC, itaf_pkg::WC_16, 32'h8000);
    send_number(itaf_pkg::OP_SDEC, WC_32, 32'h8000_0000);
    send_number(itaf_pkg::OP_SDEC, itaf_pkg::WC_8, 32'hFF);
    send_number(itaf_pkg::OP_SDEC, itaf_pkg::WC_8, 32'h7F);
    send_number(itaf_pkg::OP_SDEC, WC_32, 32'h0);
    send_number(OP_HEX, itaf_pkg::WC_8, 32'hAB);
    send_number(OP_HEX, itaf_pkg::WC_16, 32'h0000);
    send_number(OP_HEX, WC_32, 32'hDEAD_BEEF);
    send_number(OP_HEX_B, WC_32, 32'h0123_4567);
    send_number(itaf_pkg::OP_UDEC, WC_32_B, 32'h89AB_CDEF);
    send_number(itaf_pkg::OP_SDEC, WC_32_B, 32'hFFFF_FFFF);
    send_number(itaf_pkg::OP_UDEC, itaf_pkg::WC_8, 32'hFFFF_FF07);
    send_number(itaf_pkg::OP_SDEC, itaf_pkg::WC_16, 32'h1234_F000);
    send_number(OP_HEX, itaf_pkg::WC_8, 32'hFFFF_FF00);
    wait_drained();
  endtask

  // Random codes and values; value shapes bias toward short and edge numbers
  task automatic test_random(input int count);
    logic [31:0] raw;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: raw = $urandom_range(0, 20);
        1: raw = $urandom() | 32'hFFFF_FF00;
        default: raw = $urandom();
      endcase
      send_number(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), raw);
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while numbers keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_number(itaf_pkg::OP_SDEC, WC_32, $urandom());
    join
    wait_drained();
  endtask

  // Back-to-back numbers with no gaps on either side
  task automatic test_streaming();
    gaps_on = 1'b0;
    for (int i = 0; i < 20; i++)
      send_number(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)), $urandom());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_streaming();
    test_random(110);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d numbers, checked %0d characters across all formats and widths",
             numbers_sent, chars_seen);
    $display("including extremes, junk upper bits, long output hold-off and streaming");
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== integer_to_ascii_formatter.f =====
+incdir+hdl
hdl/itaf_pkg.sv
hdl/itaf_bcd.sv
hdl/itaf_emit.sv
hdl/integer_to_ascii_formatter.sv
sim/tb.sv
